/* src/mlfq_scheduler_with_boost_assert.svh */
// Assertion macros for the MLFQ scheduler.
// Used by the top level; needs aclk and aresetn in scope.
`ifndef MLFQ_SCHEDULER_WITH_BOOST_ASSERT_SVH
`define MLFQ_SCHEDULER_WITH_BOOST_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MLFQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define MLFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* src/mlfq_pkg.sv */
// Shared types and codes for the MLFQ scheduler.
// No dependencies.
`default_nettype none
package mlfq_pkg;
    localparam logic [1:0] EV_ACCEPT = 2'd0;
    localparam logic [1:0] EV_REJECT = 2'd1;
    localparam logic [1:0] EV_RAN    = 2'd2;
    localparam logic [1:0] EV_IDLE   = 2'd3;
    localparam logic       OP_ARRIVE = 1'b0;
    localparam logic       OP_TICK   = 1'b1;
    localparam logic [2:0] REG_NUM_LEVELS = 3'd0;
    localparam logic [2:0] REG_BOOST      = 3'd1;
    localparam logic [2:0] REG_SLICE0     = 3'd2;
    localparam logic [2:0] REG_SLICE3     = 3'd5;
    localparam int         LEVELS = 4;
    localparam int         MAX_PROCS = 64;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [5:0]  ran_id;
        logic        finished;
        logic        demoted;
        logic        boosted;
        logic [1:0]  new_level;
        logic [31:0] time_now;
        logic [31:0] turnaround;
    } result_t;
endpackage
`default_nettype wire

/* src/mlfq_mod_unit.sv */
// Shift-subtract unit computing time modulo boost period, one bit per cycle.
// Uses mlfq_pkg.
`default_nettype none
module mlfq_mod_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic             is_zero
);
    import mlfq_pkg::*;
    logic [16:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[15:0], quo_reg[31]};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[30:0], 1'b0};
            rem_next = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done    = !busy_reg;
    assign is_zero = (rem_reg == 17'd0);
endmodule
`default_nettype wire

/* src/mlfq_scheduler_with_boost.sv */
// Multilevel feedback queue scheduler. Items are taken one at a time; the next item is
// accepted once the previous one has handed its result to the output register. An arrive
// item passes through S_ARR and then S_OUT. A tick first runs the bit-serial modulo unit
// for the boost check, then S_SEL selects the level; an idle tick then goes to S_OUT, a
// served tick passes S_QRD, S_PRD, S_UPD and S_OUT to read the queue head and the process
// entry, update them and hand over the result. A boost adds a read state and a write state
// per moved id, one read state to close the walk and a sweep over the MAX_PROCS (64)
// entries of the process table. While a result waits at the output, the next one stalls
// in the hand-over state.
// Depends on mlfq_pkg, mlfq_mod_unit and the assertion macro header.
`default_nettype none
`include "mlfq_scheduler_with_boost_assert.svh"
module mlfq_scheduler_with_boost (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: process_id[5:0], burst_length[21:6], zero pad [23:22]
    input  wire logic [23:0] s_tdata,
    // tuser: operation
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: ran_id[5:0], finished[6], demoted[7], boosted[8], new_level[10:9],
    // time_now[42:11], turnaround[74:43], zero pad [79:75]
    output logic [79:0]      m_tdata,
    // tuser: event_res
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import mlfq_pkg::*;
    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = PW + 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_ARR   = 11'b00000000010,
        S_MOD   = 11'b00000000100,
        S_BRD   = 11'b00000001000,
        S_BWR   = 11'b00000010000,
        S_SWEEP = 11'b00000100000,
        S_SEL   = 11'b00001000000,
        S_QRD   = 11'b00010000000,
        S_PRD   = 11'b00100000000,
        S_UPD   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]  nlev_cfg_reg;
    logic [15:0] period_reg;
    logic [15:0] slice_reg [LEVELS];
    logic [31:0] time_reg;
    logic [PW-1:0] head_reg [LEVELS];
    logic [CW-1:0] count_reg [LEVELS];
    logic [MAX_PROCS-1:0] live_reg;

    // Queue store: one memory with level in the upper address bits.
    logic [PW-1:0] qmem [LEVELS*MAX_PROCS];
    logic [PW-1:0] qrd_reg;
    // Process table: burst, done, slice used, arrival.
    logic [79:0]   pmem [MAX_PROCS];
    logic [79:0]   prd_reg;

    logic [5:0]    pid_reg;
    logic [15:0]   burst_reg;
    logic [1:0]    lv_reg;
    logic [PW-1:0] sweep_reg;
    logic [PW-1:0] id_reg;
    logic          bst_reg;
    result_t       res_reg, res_next;
    result_t       out_reg;
    logic          mvalid_reg;

    logic          mod_start, mod_done, mod_zero;
    logic [2:0]    nl;
    logic [1:0]    serve_lv;
    logic          any_ready;

    mlfq_mod_unit u_mod (
        .aclk(aclk), .aresetn(aresetn), .start(mod_start),
        .dividend(time_reg), .divisor((period_reg == 16'd0) ? 16'd1 : period_reg),
        .done(mod_done), .is_zero(mod_zero)
    );

    assign nl = (nlev_cfg_reg == 3'd0) ? 3'd1 :
                (nlev_cfg_reg > 3'(LEVELS)) ? 3'(LEVELS) : nlev_cfg_reg;

    always_comb begin
        serve_lv  = 2'd0;
        any_ready = 1'b0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (3'(l) < nl && count_reg[l] != '0) begin
                serve_lv  = 2'(l);
                any_ready = 1'b1;
            end
        end
    end

    // Fields of the read process entry.
    logic [15:0] p_burst, p_done, p_used, done_inc, used_inc, sl;
    logic [31:0] p_arr;
    logic [1:0]  nlv;
    logic        fin, spent;
    assign p_burst  = prd_reg[15:0];
    assign p_done   = prd_reg[31:16];
    assign p_used   = prd_reg[47:32];
    assign p_arr    = prd_reg[79:48];
    assign done_inc = p_done + 16'd1;
    assign used_inc = p_used + 16'd1;
    assign sl       = (slice_reg[lv_reg] == 16'd0) ? 16'd1 : slice_reg[lv_reg];
    assign fin      = done_inc >= p_burst;
    assign spent    = used_inc >= sl;
    assign nlv      = (3'(lv_reg) + 3'd1 < nl) ? lv_reg + 2'd1 : 2'(nl - 3'd1);

    logic          s_acc;
    logic          pid_ok;
    logic          arr_ok;
    logic          out_load;
    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign pid_ok   = ({26'd0, pid_reg} < 32'(MAX_PROCS));
    assign arr_ok   = pid_ok && !live_reg[PW'(pid_reg)];
    assign mod_start = (state_reg == S_IDLE) && s_acc && (s_tuser == OP_TICK);
    // The finished result moves to the output register once that register is free.
    assign out_load = (state_reg == S_OUT) && (!mvalid_reg || m_tready);

    logic [1:0] blv;  // first nonempty level 1..3 for the boost walk
    logic       bany;
    always_comb begin
        blv  = 2'd1;
        bany = 1'b0;
        for (int l = LEVELS - 1; l >= 1; l--) begin
            if (count_reg[l] != '0) begin
                blv  = 2'(l);
                bany = 1'b1;
            end
        end
    end

    always_comb begin
        res_next = res_reg;
        case (state_reg)
            S_ARR: begin
                res_next           = '0;
                res_next.ran_id    = pid_reg;
                res_next.time_now  = time_reg;
                res_next.event_res = arr_ok ? EV_ACCEPT : EV_REJECT;
            end
            S_SEL: begin
                res_next           = '0;
                res_next.boosted   = bst_reg;
                res_next.event_res = EV_IDLE;
                res_next.time_now  = time_reg + 32'd1;
            end
            S_UPD: begin
                res_next.event_res = EV_RAN;
                res_next.ran_id    = 6'(id_reg);
                res_next.new_level = lv_reg;
                if (fin) begin
                    res_next.finished   = 1'b1;
                    res_next.turnaround = time_reg - p_arr;
                end else if (spent) begin
                    res_next.demoted   = (nlv != lv_reg);
                    res_next.new_level = nlv;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_acc) state_next = (s_tuser == OP_TICK) ? S_MOD : S_ARR;
            S_ARR:   state_next = S_OUT;
            S_MOD:   if (mod_done) state_next = mod_zero ? S_BRD : S_SEL;
            S_BRD:   state_next = bany ? S_BWR : S_SWEEP;
            S_BWR:   state_next = S_BRD;
            S_SWEEP: if (sweep_reg == PW'(MAX_PROCS - 1)) state_next = S_SEL;
            S_SEL:   state_next = any_ready ? S_QRD : S_OUT;
            S_QRD:   state_next = S_PRD;
            S_PRD:   state_next = S_UPD;
            S_UPD:   state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nlev_cfg_reg <= 3'd3;
            period_reg   <= 16'd100;
            slice_reg[0] <= 16'd1;
            slice_reg[1] <= 16'd2;
            slice_reg[2] <= 16'd4;
            slice_reg[3] <= 16'd8;
            time_reg     <= '0;
            live_reg     <= '0;
            mvalid_reg   <= 1'b0;
            sweep_reg    <= '0;
            res_reg      <= '0;
            out_reg      <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
            if (cfg_we) begin
                if (cfg_index == REG_NUM_LEVELS) nlev_cfg_reg <= cfg_wdata[2:0];
                else if (cfg_index == REG_BOOST) period_reg <= cfg_wdata;
                else if (cfg_index >= REG_SLICE0 && cfg_index <= REG_SLICE3)
                    slice_reg[2'(cfg_index - REG_SLICE0)] <= cfg_wdata;
            end
            if (out_load) begin
                mvalid_reg <= 1'b1;
                out_reg    <= res_reg;
            end else if (m_tvalid && m_tready) begin
                mvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    sweep_reg <= '0;
                    bst_reg   <= 1'b0;
                    if (s_acc) begin
                        pid_reg   <= s_tdata[5:0];
                        burst_reg <= s_tdata[21:6];
                    end
                end
                S_ARR: begin
                    if (arr_ok) begin
                        live_reg[PW'(pid_reg)] <= 1'b1;
                        if (count_reg[0] != CW'(MAX_PROCS)) count_reg[0] <= count_reg[0] + 1'b1;
                    end
                end
                S_MOD: if (mod_done) bst_reg <= mod_zero;
                S_BRD: if (bany) begin
                    head_reg[blv]  <= head_reg[blv] + 1'b1;
                    count_reg[blv] <= count_reg[blv] - 1'b1;
                end
                S_BWR: count_reg[0] <= count_reg[0] + 1'b1;
                S_SWEEP: sweep_reg <= sweep_reg + 1'b1;
                S_SEL: begin
                    lv_reg   <= serve_lv;
                    time_reg <= time_reg + 32'd1;
                end
                S_PRD: id_reg <= qrd_reg;
                S_UPD: begin
                    if (fin) begin
                        live_reg[id_reg]   <= 1'b0;
                        head_reg[lv_reg]   <= head_reg[lv_reg] + 1'b1;
                        count_reg[lv_reg]  <= count_reg[lv_reg] - 1'b1;
                    end else if (spent) begin
                        head_reg[lv_reg]  <= head_reg[lv_reg] + 1'b1;
                        if (nlv != lv_reg) begin
                            count_reg[lv_reg] <= count_reg[lv_reg] - 1'b1;
                            count_reg[nlv]    <= count_reg[nlv] + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Memory ports.
    logic [PW-1:0] bid_reg;
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_ARR: if (arr_ok) begin
                qmem[{2'd0, PW'(head_reg[0] + PW'(count_reg[0]))}] <= PW'(pid_reg);
                pmem[PW'(pid_reg)] <= {time_reg, 32'd0, burst_reg};
            end
            S_BRD: bid_reg <= qmem[{blv, head_reg[blv]}];
            S_BWR: qmem[{2'd0, PW'(head_reg[0] + PW'(count_reg[0]))}] <= bid_reg;
            S_SWEEP: if (live_reg[sweep_reg]) begin
                pmem[sweep_reg][47:32] <= 16'd0;
            end
            S_QRD: qrd_reg <= qmem[{lv_reg, head_reg[lv_reg]}];
            S_PRD: prd_reg <= pmem[qrd_reg];
            S_UPD: begin
                pmem[id_reg] <= {p_arr, (spent && !fin) ? 16'd0 : used_inc, done_inc, p_burst};
                if (!fin && spent)
                    qmem[{nlv, PW'(head_reg[nlv] + PW'(count_reg[nlv]))}] <= id_reg;
            end
            default: ;
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {5'd0, out_reg.turnaround, out_reg.time_now, out_reg.new_level,
                       out_reg.boosted, out_reg.demoted, out_reg.finished, out_reg.ran_id};

    `MLFQ_ASSERT_IMP(a_ready_idle, s_tready, state_reg == S_IDLE, "ready outside idle")
    `MLFQ_ASSERT_IMP(a_one_state, 1'b1, $onehot(state_reg), "state not one-hot")
    `MLFQ_ASSERT_NEXT(a_out_valid, state_reg == S_OUT, m_tvalid, "result not presented")
    `MLFQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
endmodule
`default_nettype wire

/* tb/mlfq_scheduler_with_boost_tb.sv */
// Self-checking testbench for the MLFQ scheduler: random arrivals and ticks
// under several register settings, checked against an in-bench scheduler model.
// Depends on mlfq_pkg and mlfq_scheduler_with_boost.
`default_nettype none
module mlfq_scheduler_with_boost_tb;
    import mlfq_pkg::*;

    localparam int NPROC     = MAX_PROCS;
    localparam int WDOG_MAX  = 20000;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 190;
    localparam int REG_SPARE_A = 6;
    localparam int REG_SPARE_B = 7;

    class sched_scoreboard;
        int unsigned nlev;
        int unsigned bperiod;
        int unsigned slice[LEVELS];
        bit [31:0]   tnow;
        int          lq[LEVELS][$];
        bit [15:0]   burst[NPROC];
        bit [15:0]   done[NPROC];
        bit [15:0]   used[NPROC];
        bit [31:0]   arr[NPROC];
        bit          live[NPROC];
        result_t     sched_expect_q[$];
        int          errors;

        function new();
            nlev = 3;
            bperiod = 100;
            slice = '{1, 2, 4, 8};
            tnow = 0;
            errors = 0;
            foreach (live[i]) live[i] = 0;
        endfunction

        function void set_reg(int idx, int val);
            if (idx == REG_NUM_LEVELS) nlev = val & 7;
            else if (idx == REG_BOOST) bperiod = val & 16'hFFFF;
            else if (idx >= REG_SLICE0 && idx <= REG_SLICE3)
                slice[idx - REG_SLICE0] = val & 16'hFFFF;
        endfunction

        // Works out the result of one accepted item and queues it.
        function void note_item(logic op, int pid, bit [15:0] blen);
            result_t r;
            int unsigned period, nl, sl;
            int lv, nlv, id;
            r = '0;
            if (op == OP_ARRIVE) begin
                r.ran_id = 6'(pid);
                if (live[pid]) begin
                    r.event_res = EV_REJECT;
                end else begin
                    r.event_res = EV_ACCEPT;
                    live[pid] = 1;
                    burst[pid] = blen;
                    done[pid] = 0;
                    used[pid] = 0;
                    arr[pid] = tnow;
                    lq[0].push_back(pid);
                end
            end else begin
                period = bperiod ? bperiod : 1;
                nl = (nlev == 0) ? 1 : (nlev > LEVELS) ? LEVELS : nlev;
                if (tnow % period == 0) begin
                    r.boosted = 1;
                    for (int l = 1; l < LEVELS; l++)
                        while (lq[l].size() != 0) lq[0].push_back(lq[l].pop_front());
                    foreach (live[i]) if (live[i]) used[i] = 0;
                end
                for (lv = 0; lv < nl; lv++)
                    if (lq[lv].size() != 0) break;
                tnow++;
                if (lv == nl) begin
                    r.event_res = EV_IDLE;
                end else begin
                    id = lq[lv][0];
                    sl = slice[lv] ? slice[lv] : 1;
                    r.event_res = EV_RAN;
                    r.ran_id = 6'(id);
                    r.new_level = 2'(lv);
                    done[id]++;
                    used[id]++;
                    if (done[id] >= burst[id]) begin
                        r.finished = 1;
                        void'(lq[lv].pop_front());
                        live[id] = 0;
                        r.turnaround = tnow - arr[id];
                    end else if (used[id] >= sl) begin
                        nlv = (lv + 1 < nl) ? lv + 1 : nl - 1;
                        void'(lq[lv].pop_front());
                        used[id] = 0;
                        r.demoted = (nlv != lv);
                        r.new_level = 2'(nlv);
                        lq[nlv].push_back(id);
                    end
                end
            end
            r.time_now = tnow;
            sched_expect_q.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t e;
            if (sched_expect_q.size() == 0) begin
                report("result with none expected");
                return;
            end
            e = sched_expect_q.pop_front();
            if (got.event_res != e.event_res)
                report($sformatf("event %0d exp %0d", got.event_res, e.event_res));
            if (got.ran_id != e.ran_id)
                report($sformatf("ran_id %0d exp %0d", got.ran_id, e.ran_id));
            if (got.finished != e.finished)
                report($sformatf("finished %0d exp %0d", got.finished, e.finished));
            if (got.demoted != e.demoted)
                report($sformatf("demoted %0d exp %0d", got.demoted, e.demoted));
            if (got.boosted != e.boosted)
                report($sformatf("boosted %0d exp %0d", got.boosted, e.boosted));
            if (got.new_level != e.new_level)
                report($sformatf("new_level %0d exp %0d", got.new_level, e.new_level));
            if (got.time_now != e.time_now)
                report($sformatf("time_now %0d exp %0d", got.time_now, e.time_now));
            if (got.turnaround != e.turnaround)
                report($sformatf("turnaround %0d exp %0d", got.turnaround, e.turnaround));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    sched_scoreboard sb = new();
    int wdog = 0;

    always #1 aclk = ~aclk;

    mlfq_scheduler_with_boost u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, and every accepted item is checked.
    always @(posedge aclk) begin
        result_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '0;
                got.event_res  = m_tuser;
                got.ran_id     = m_tdata[5:0];
                got.finished   = m_tdata[6];
                got.demoted    = m_tdata[7];
                got.boosted    = m_tdata[8];
                got.new_level  = m_tdata[10:9];
                got.time_now   = m_tdata[42:11];
                got.turnaround = m_tdata[74:43];
                sb.check_result(got);
            end
            m_tready <= (pick_gap() == 0) || ($urandom_range(0, 1) == 1);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            wdog <= 0;
        end else if (wdog >= WDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    task automatic send_item(logic op, int pid, bit [15:0] blen);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, blen, pid[5:0]};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, pid, blen);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.sched_expect_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(int idx, int val);
        cfg_we    <= 1;
        cfg_index <= 3'(idx);
        cfg_wdata <= 16'(val);
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    function automatic bit [15:0] pick_burst();
        int p;
        p = $urandom_range(0, 99);
        if (p < 4) return 16'd0;
        if (p < 6) return 16'($urandom_range(0, 65535));
        if (p < 80) return 16'($urandom_range(1, 6));
        return 16'($urandom_range(7, 30));
    endfunction

    initial begin
        int nl, bp, sl;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes of the fields, a live-id rejection, zero burst,
        // a boost at time zero, idle ticks on empty queues.
        send_item(OP_TICK, 0, 0);
        send_item(OP_ARRIVE, 0, 0);
        send_item(OP_ARRIVE, 63, 16'hFFFF);
        send_item(OP_ARRIVE, 63, 3);
        send_item(OP_ARRIVE, 42, 16'hAAAA);
        send_item(OP_ARRIVE, 21, 5);
        repeat (8) send_item(OP_TICK, 0, 0);
        send_item(OP_ARRIVE, 0, 2);
        repeat (6) send_item(OP_TICK, 0, 0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin nl = 1; bp = 1;     sl = 0;     end
                1: begin nl = 4; bp = 65535; sl = 65535; end
                2: begin nl = 0; bp = 0;     sl = 1;     end
                3: begin nl = 7; bp = 7;     sl = -1;    end
                default: begin
                    nl = $urandom_range(0, 7);
                    bp = $urandom_range(1, 60);
                    sl = -1;
                end
            endcase
            write_reg(REG_NUM_LEVELS, nl);
            write_reg(REG_BOOST, bp);
            for (int r = REG_SLICE0; r <= REG_SLICE3; r++)
                write_reg(r, (sl < 0) ? $urandom_range(1, 6) : sl);
            // Unused indexes must have no effect.
            if (p == 0) begin
                write_reg(REG_SPARE_A, 16'hFFFF);
                write_reg(REG_SPARE_B, 16'h5555);
            end
            cfg_we <= 0;
            @(posedge aclk);
            for (int i = 0; i < PHASE_LEN; i++) begin
                if ($urandom_range(0, 99) < 40)
                    send_item(OP_ARRIVE, $urandom_range(0, NPROC - 1), pick_burst());
                else
                    send_item(OP_TICK, $urandom_range(0, NPROC - 1), 16'($urandom_range(0, 65535)));
            end
            drain();
        end

        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.sched_expect_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+src
src/mlfq_pkg.sv
src/mlfq_mod_unit.sv
src/mlfq_scheduler_with_boost.sv
tb/mlfq_scheduler_with_boost_tb.sv
